[hdl/matrix_history_average_filter_top_defines.svh]
// ----------------------------------------------------------------------------
// Matrix history average filter assertion macros
// Concurrent assertion helpers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX_HISTORY_AVERAGE_FILTER_TOP_DEFINES_SVH
`define MATRIX_HISTORY_AVERAGE_FILTER_TOP_DEFINES_SVH

`ifndef SYNTH
`define MHAF_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
`define MHAF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define MHAF_ASSERT_IMPLIES(lbl, ante, cons)
`define MHAF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[hdl/mhaf_pkg.sv]
// ----------------------------------------------------------------------------
// Matrix history average filter package
// Shared sizes, types and ring helpers for the filter and its divider.
// ----------------------------------------------------------------------------
package mhaf_pkg;

  localparam int HIST_DEPTH = 16;
  localparam int NENT       = 9;
  localparam int DATA_W     = 32;
  localparam int WIN_W      = 4;
  localparam logic [WIN_W-1:0] WIN_RESET = 4'd5;

  localparam int CNT_W   = $clog2(HIST_DEPTH + 1);
  localparam int SLOT_W  = $clog2(HIST_DEPTH);
  localparam int ENT_W   = $clog2(NENT);
  localparam int ADDR_W  = $clog2(HIST_DEPTH * NENT);
  localparam int SUM_W   = DATA_W + $clog2(HIST_DEPTH + 1);
  localparam int MAG_W   = SUM_W - 1;
  localparam int DV_W    = $clog2(HIST_DEPTH + 2);
  localparam int DSTEP_W = $clog2(MAG_W + 1);
  localparam int RSUM_W  = CNT_W + 1;
  localparam int CMP_W   = (CNT_W > WIN_W) ? CNT_W : WIN_W;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  function automatic logic [SLOT_W-1:0] ring(input logic [SLOT_W-1:0] base,
                                             input logic [CNT_W-1:0]  ofs);
    logic [RSUM_W-1:0] s;
    s = RSUM_W'(base) + RSUM_W'(ofs);
    if (s >= RSUM_W'(HIST_DEPTH)) s = s - RSUM_W'(HIST_DEPTH);
    return s[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] base);
    logic [RSUM_W-1:0] s;
    s = RSUM_W'(base) + RSUM_W'(1);
    if (s >= RSUM_W'(HIST_DEPTH)) s = '0;
    return s[SLOT_W-1:0];
  endfunction

endpackage

[hdl/mhaf_div.sv]
// ----------------------------------------------------------------------------
// Matrix history average filter divider
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module mhaf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  mhaf_pkg::sum_t              dividend,
  input  logic [mhaf_pkg::DV_W-1:0]   divisor,
  output logic                        done,
  output mhaf_pkg::data_t             quotient
);
  import mhaf_pkg::*;

  logic               busy_r;
  logic               done_r;
  logic [DSTEP_W-1:0] cnt_r;
  logic               neg_r;
  logic [DV_W-1:0]    dvs_r;
  logic [DV_W-1:0]    rem_r;
  logic [MAG_W-1:0]   quo_r;

  sum_t               neg_dividend;
  logic [DV_W:0]      trial;
  logic [DV_W:0]      diff;
  logic               ge;
  logic [MAG_W-1:0]   quo_neg;

  assign neg_dividend = -dividend;
  assign trial = {rem_r, quo_r[MAG_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};
  assign quo_neg = -quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == DSTEP_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DSTEP_W'(MAG_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DSTEP_W'(1);
        if (cnt_r == DSTEP_W'(1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= dividend[SUM_W-1] ? neg_dividend[MAG_W-1:0] : dividend[MAG_W-1:0];
    end else if (busy_r) begin
      rem_r <= ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
      quo_r <= {quo_r[MAG_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? quo_neg[DATA_W-1:0] : quo_r[DATA_W-1:0];

endmodule

[hdl/matrix_history_average_filter_top.sv]
// ----------------------------------------------------------------------------
// Matrix history average filter
// Moving average of 3x3 Q16.16 matrices over a ring of past outputs.
// ----------------------------------------------------------------------------
// Input transaction: in_valid with in_valid_pose and nine entries, taken when
// in_stall is low; in_stall stays high from acceptance until the result
// transaction has been taken. One item is in flight at a time.
// Result transaction: out_valid with out_h00..out_h22; held steady while
// out_stall is high.
// Configuration: cfg_valid/cfg_ready write the 4-bit window; cfg_ready is
// always high, write only while idle.
// Processing with c stored outputs: per entry an accumulate pass through the
// history memory read port, then a division in the shared serial divider;
// then one update step, a write-back of the nine entries and the output
// state. A valid item sums its input with all c stored outputs; an invalid
// item reads only the newest output, or none when the store is empty.
// The block returns to idle before the next input is taken. Entries are
// handled one at a time through the one memory port and the one divider.
// Reset clears the store count, ring position and sets window to 5; history
// memory contents are not cleared. A stalled result blocks the next input.
// ----------------------------------------------------------------------------
`include "matrix_history_average_filter_top_defines.svh"

module matrix_history_average_filter_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_valid_pose,
  input  mhaf_pkg::data_t              in_h00,
  input  mhaf_pkg::data_t              in_h01,
  input  mhaf_pkg::data_t              in_h02,
  input  mhaf_pkg::data_t              in_h10,
  input  mhaf_pkg::data_t              in_h11,
  input  mhaf_pkg::data_t              in_h12,
  input  mhaf_pkg::data_t              in_h20,
  input  mhaf_pkg::data_t              in_h21,
  input  mhaf_pkg::data_t              in_h22,
  output logic                         out_valid,
  input  logic                         out_stall,
  output mhaf_pkg::data_t              out_h00,
  output mhaf_pkg::data_t              out_h01,
  output mhaf_pkg::data_t              out_h02,
  output mhaf_pkg::data_t              out_h10,
  output mhaf_pkg::data_t              out_h11,
  output mhaf_pkg::data_t              out_h12,
  output mhaf_pkg::data_t              out_h20,
  output mhaf_pkg::data_t              out_h21,
  output mhaf_pkg::data_t              out_h22,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mhaf_pkg::WIN_W-1:0]   cfg_data
);
  import mhaf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ACC  = 6'b000010,
    S_DIV  = 6'b000100,
    S_UPD  = 6'b001000,
    S_WR   = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t             state_r;
  logic [WIN_W-1:0]   window_r;
  logic [CNT_W-1:0]   count_r;
  logic [SLOT_W-1:0]  oldest_r;
  logic [SLOT_W-1:0]  wslot_r;
  logic [ENT_W-1:0]   j_r;
  logic [CNT_W-1:0]   k_r;
  logic [CNT_W-1:0]   kstart_r;
  logic               pend_r;
  logic               pose_r;
  sum_t               acc_r;
  data_t              in_r  [NENT];
  data_t              res_r [NENT];
  data_t              rdata_r;
  data_t              mem [HIST_DEPTH * NENT];

  data_t              in_ent [NENT];
  logic               in_acc;
  logic               rd_issue;
  logic               div_start;
  logic               div_done;
  data_t              div_q;
  logic [DV_W-1:0]    divisor;
  logic [ADDR_W-1:0]  raddr;
  logic [ADDR_W-1:0]  waddr;
  logic               mem_we;
  logic               last_ent;

  logic [SLOT_W-1:0]  upd_o1;
  logic [SLOT_W-1:0]  upd_o2;
  logic [CNT_W-1:0]   upd_c1;
  logic [CNT_W-1:0]   upd_c2;

  assign in_ent[0] = in_h00;
  assign in_ent[1] = in_h01;
  assign in_ent[2] = in_h02;
  assign in_ent[3] = in_h10;
  assign in_ent[4] = in_h11;
  assign in_ent[5] = in_h12;
  assign in_ent[6] = in_h20;
  assign in_ent[7] = in_h21;
  assign in_ent[8] = in_h22;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_OUT);

  assign rd_issue  = (state_r == S_ACC) && (k_r != count_r);
  assign div_start = (state_r == S_ACC) && (k_r == count_r) && !pend_r;
  assign divisor   = pose_r ? (DV_W'(count_r) + DV_W'(1)) : DV_W'(1);
  assign last_ent  = (j_r == ENT_W'(NENT - 1));

  assign raddr  = ADDR_W'(ring(oldest_r, k_r)) * ADDR_W'(NENT) + ADDR_W'(j_r);
  assign waddr  = ADDR_W'(wslot_r) * ADDR_W'(NENT) + ADDR_W'(j_r);
  assign mem_we = (state_r == S_WR);

  always_comb begin
    upd_o1 = oldest_r;
    upd_c1 = count_r;
    if (pose_r && (CMP_W'(count_r) > CMP_W'(window_r))) begin
      upd_o1 = slot_inc(oldest_r);
      upd_c1 = count_r - CNT_W'(1);
    end
    upd_o2 = upd_o1;
    upd_c2 = upd_c1;
    if (upd_c1 == CNT_W'(HIST_DEPTH)) begin
      upd_o2 = slot_inc(upd_o1);
      upd_c2 = upd_c1 - CNT_W'(1);
    end
  end

  mhaf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= res_r[j_r];
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      window_r <= WIN_RESET;
      count_r  <= '0;
      oldest_r <= '0;
      pend_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) window_r <= cfg_data;
      pend_r <= rd_issue;
      case (state_r)
        S_IDLE: begin
          if (in_acc) state_r <= S_ACC;
        end
        S_ACC: begin
          if (div_start) state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) state_r <= last_ent ? S_UPD : S_ACC;
        end
        S_UPD: begin
          oldest_r <= upd_o2;
          count_r  <= upd_c2 + CNT_W'(1);
          state_r  <= S_WR;
        end
        S_WR: begin
          if (last_ent) state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pose_r <= in_valid_pose;
          in_r   <= in_ent;
          j_r    <= '0;
          if (in_valid_pose || count_r == '0) begin
            kstart_r <= '0;
            k_r      <= '0;
          end else begin
            kstart_r <= count_r - CNT_W'(1);
            k_r      <= count_r - CNT_W'(1);
          end
          acc_r <= in_valid_pose ? SUM_W'(in_ent[0]) : '0;
        end
      end
      S_ACC: begin
        if (rd_issue) k_r <= k_r + CNT_W'(1);
        if (pend_r) acc_r <= acc_r + SUM_W'(rdata_r);
      end
      S_DIV: begin
        if (div_done) begin
          res_r[j_r] <= div_q;
          if (!last_ent) begin
            j_r   <= j_r + ENT_W'(1);
            k_r   <= kstart_r;
            acc_r <= pose_r ? SUM_W'(in_r[j_r + ENT_W'(1)]) : '0;
          end
        end
      end
      S_UPD: begin
        wslot_r <= ring(upd_o2, upd_c2);
        j_r     <= '0;
      end
      S_WR: begin
        if (!last_ent) j_r <= j_r + ENT_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign out_h00 = res_r[0];
  assign out_h01 = res_r[1];
  assign out_h02 = res_r[2];
  assign out_h10 = res_r[3];
  assign out_h11 = res_r[4];
  assign out_h12 = res_r[5];
  assign out_h20 = res_r[6];
  assign out_h21 = res_r[7];
  assign out_h22 = res_r[8];

  `MHAF_ASSERT_IMPLIES(a_count_bound, 1'b1, count_r <= CNT_W'(HIST_DEPTH))
  `MHAF_ASSERT_IMPLIES(a_oldest_bound, 1'b1, RSUM_W'(oldest_r) < RSUM_W'(HIST_DEPTH))
  `MHAF_ASSERT_IMPLIES(a_div_done_state, div_done, state_r == S_DIV)
  `MHAF_ASSERT_IMPLIES(a_out_stored, out_valid && !out_stall, count_r != '0)
  `MHAF_ASSERT_NEXT(a_acc_after_accept, in_acc, state_r == S_ACC && !pend_r)

endmodule
